// File: hdl/ffa_pkg.sv
// Shared constants and the sequencer state type of the first-fit allocator.
package ffa_pkg;

  localparam int unsigned HEAP_UNITS = 65536;
  localparam int unsigned UNIT_BYTES = 16;
  localparam int unsigned UNIT_SHIFT = $clog2(UNIT_BYTES);
  localparam int unsigned REQ_W      = 20;
  localparam int unsigned UNIT_W     = 16;
  localparam int unsigned NEED_W     = REQ_W - UNIT_SHIFT + 1;
  localparam logic [UNIT_W-1:0] GROW_RESET = 16'd1024;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_A_START,
    ST_A_FIRST,
    ST_A_CHECK,
    ST_A_SPLIT,
    ST_G_ROOM,
    ST_G_CHK,
    ST_G_TOP,
    ST_F_START,
    ST_F_CHK,
    ST_I_START,
    ST_I_WALK,
    ST_I_UP,
    ST_I_LOW,
    ST_I_WB,
    ST_I_LOW2,
    ST_RESP
  } st_e;

endpackage

// File: hdl/first_fit_free_list_allocator.sv
// Top level of the first-fit free-list allocator: sequencer, datapath and header stores.
//
//  channel   | direction | tdata (low bit up)                 | tuser
//  s_axis    | in        | request_bytes[19:0], block_unit     | mode (0 alloc, 1 free)
//  m_axis    | out       | payload_unit[15:0]                  | failed
//  cfg       | in        | min_grow_units[15:0] on cfg_we_i    | -
//
// After reset a clearing pass writes every header entry, with no transfer taken. An allocate
// walks the free list over the header stores from the cursor until a block fits, and splits
// that block when it is larger than needed; a refill grows the arena and then inserts the new
// block as a free does. A free checks the block and inserts it by an address-ordered walk. One item is
// worked on at a time, and the next is taken while its result still waits in the output register.
module first_fit_free_list_allocator #(
  parameter int unsigned HeapUnits = ffa_pkg::HEAP_UNITS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // request_bytes[19:0], block_unit[35:20], zeros
  input  logic        s_axis_tuser,   // mode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // payload_unit[15:0]
  output logic        m_axis_tuser,   // failed
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i
);

  localparam int unsigned AW = $clog2(HeapUnits);
  localparam int unsigned CW = ((AW > ffa_pkg::NEED_W) ? AW : ffa_pkg::NEED_W) + 1;
  localparam int unsigned NW = ffa_pkg::NEED_W;
  localparam logic [CW-1:0] LastUnit = CW'(HeapUnits - 1);
  localparam logic [AW-1:0] LastAddr = AW'(HeapUnits - 1);

  ffa_pkg::st_e st_q, st_d;

  logic [AW-1:0] cursor_q, cursor_d, top_q, top_d, clr_q, clr_d;
  logic [AW-1:0] prev_q, prev_d, p_q, p_d, bp_q, bp_d, bsize_q, bsize_d;
  logic [AW-1:0] up_q, up_d, upsz_q, upsz_d, upnx_q, upnx_d, bnext_q, bnext_d;
  logic [AW-1:0] psz_q, psz_d, hdr_q, hdr_d;
  logic [CW-1:0] room_q, room_d;
  logic [NW-1:0] n_q, n_d;
  logic [15:0]   bu_q, bu_d, grow_q, grow_d;
  logic          mu_q, mu_d, ml_q, ml_d, gctx_q, gctx_d, ok_q, ok_d, fail_q, fail_d;
  logic          mv_q, mv_d, mu_fail_q, mu_fail_d;
  logic [15:0]   md_q, md_d;

  logic [CW-1:0] alu_a, alu_b, alu_res;
  logic          alu_sub, alu_carry;

  logic          nx_we, sz_we, lv_we, lv_wdata, lv_rdata;
  logic [AW-1:0] nx_waddr, nx_wdata, nx_raddr, nx_rdata;
  logic [AW-1:0] sz_waddr, sz_wdata, sz_raddr, sz_rdata;
  logic [AW-1:0] lv_waddr, lv_raddr;

  logic          accept, slot_free, walk_stop, free_ok, fit_ge, fit_eq;
  logic [CW-1:0] g_need, g_units;
  logic [NW-1:0] n_calc;
  logic [CW-1:0] pay_sum;

  ffa_alu #(.Width(CW)) u_alu (
    .a_i    (alu_a),
    .b_i    (alu_b),
    .sub_i  (alu_sub),
    .res_o  (alu_res),
    .carry_o(alu_carry)
  );

  ffa_ram #(.Width(AW), .Depth(HeapUnits)) u_next_ram (
    .clk_i, .we_i(nx_we), .waddr_i(nx_waddr), .wdata_i(nx_wdata),
    .raddr_i(nx_raddr), .rdata_o(nx_rdata)
  );

  ffa_ram #(.Width(AW), .Depth(HeapUnits)) u_size_ram (
    .clk_i, .we_i(sz_we), .waddr_i(sz_waddr), .wdata_i(sz_wdata),
    .raddr_i(sz_raddr), .rdata_o(sz_rdata)
  );

  ffa_ram #(.Width(1), .Depth(HeapUnits)) u_live_ram (
    .clk_i, .we_i(lv_we), .waddr_i(lv_waddr), .wdata_i(lv_wdata),
    .raddr_i(lv_raddr), .rdata_o(lv_rdata)
  );

  assign s_axis_tready = (st_q == ffa_pkg::ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign slot_free     = !mv_q || m_axis_tready;
  assign m_axis_tvalid = mv_q;
  assign m_axis_tdata  = md_q;
  assign m_axis_tuser  = mu_fail_q;

  // Units needed: payload rounded up to whole units plus one header unit.
  assign n_calc = NW'(((({1'b0, s_axis_tdata[19:0]}
                  + 21'(ffa_pkg::UNIT_BYTES - 1)) >> ffa_pkg::UNIT_SHIFT) + 21'd1));

  // The insertion point is found when bp lies between p and its successor,
  // or p is the highest free block and bp lies beyond either end.
  assign walk_stop = ((bp_q > p_q) && (bp_q < nx_rdata)) ||
                     ((p_q >= nx_rdata) && ((bp_q > p_q) || (bp_q < nx_rdata)));
  assign free_ok   = (bu_q != 16'd0) && (alu_res < CW'(top_q));
  assign fit_ge    = alu_carry;
  assign fit_eq    = (alu_res == '0);
  assign g_need    = (CW'(n_q) < CW'(grow_q)) ? CW'(grow_q) : CW'(n_q);
  assign g_units   = (g_need > room_q) ? room_q : g_need;
  assign pay_sum   = CW'(hdr_q) + CW'(1);

  // Next state.
  always_comb begin
    st_d = st_q;
    case (st_q)
      ffa_pkg::ST_CLEAR:   if (clr_q == LastAddr) st_d = ffa_pkg::ST_IDLE;
      ffa_pkg::ST_IDLE: begin
        if (accept) st_d = s_axis_tuser ? ffa_pkg::ST_F_START : ffa_pkg::ST_A_START;
      end
      ffa_pkg::ST_A_START: st_d = ffa_pkg::ST_A_FIRST;
      ffa_pkg::ST_A_FIRST: st_d = ffa_pkg::ST_A_CHECK;
      ffa_pkg::ST_A_CHECK: begin
        if (fit_ge) st_d = fit_eq ? ffa_pkg::ST_RESP : ffa_pkg::ST_A_SPLIT;
        else if (p_q == cursor_q) st_d = ffa_pkg::ST_G_ROOM;
      end
      ffa_pkg::ST_A_SPLIT: st_d = ffa_pkg::ST_RESP;
      ffa_pkg::ST_G_ROOM:  st_d = ffa_pkg::ST_G_CHK;
      ffa_pkg::ST_G_CHK:   st_d = (room_q < CW'(n_q)) ? ffa_pkg::ST_RESP : ffa_pkg::ST_G_TOP;
      ffa_pkg::ST_G_TOP:   st_d = ffa_pkg::ST_I_START;
      ffa_pkg::ST_F_START: st_d = free_ok ? ffa_pkg::ST_F_CHK : ffa_pkg::ST_RESP;
      ffa_pkg::ST_F_CHK:   st_d = lv_rdata ? ffa_pkg::ST_I_START : ffa_pkg::ST_RESP;
      ffa_pkg::ST_I_START: st_d = ffa_pkg::ST_I_WALK;
      ffa_pkg::ST_I_WALK:  if (walk_stop) st_d = ffa_pkg::ST_I_UP;
      ffa_pkg::ST_I_UP:    st_d = ffa_pkg::ST_I_LOW;
      ffa_pkg::ST_I_LOW:   st_d = ffa_pkg::ST_I_WB;
      ffa_pkg::ST_I_WB:    st_d = ffa_pkg::ST_I_LOW2;
      ffa_pkg::ST_I_LOW2:  st_d = gctx_q ? ffa_pkg::ST_A_START : ffa_pkg::ST_RESP;
      ffa_pkg::ST_RESP:    if (slot_free) st_d = ffa_pkg::ST_IDLE;
      default:             st_d = ffa_pkg::ST_IDLE;
    endcase
  end

  // Datapath, shared unit operands and header store accesses.
  always_comb begin
    cursor_d = cursor_q; top_d = top_q; clr_d = clr_q; prev_d = prev_q; p_d = p_q;
    bp_d = bp_q; bsize_d = bsize_q; up_d = up_q; upsz_d = upsz_q; upnx_d = upnx_q;
    bnext_d = bnext_q; psz_d = psz_q; hdr_d = hdr_q; room_d = room_q; n_d = n_q;
    bu_d = bu_q; mu_d = mu_q; ml_d = ml_q; gctx_d = gctx_q; ok_d = ok_q; fail_d = fail_q;
    grow_d = cfg_we_i ? cfg_wdata_i : grow_q;
    mv_d = mv_q && !m_axis_tready; md_d = md_q; mu_fail_d = mu_fail_q;
    alu_a = '0; alu_b = '0; alu_sub = 1'b0;
    nx_we = 1'b0; nx_waddr = '0; nx_wdata = '0; nx_raddr = '0;
    sz_we = 1'b0; sz_waddr = '0; sz_wdata = '0; sz_raddr = '0;
    lv_we = 1'b0; lv_waddr = '0; lv_wdata = 1'b0; lv_raddr = '0;
    case (st_q)
      ffa_pkg::ST_CLEAR: begin
        nx_we = 1'b1; nx_waddr = clr_q;
        sz_we = 1'b1; sz_waddr = clr_q;
        lv_we = 1'b1; lv_waddr = clr_q;
        clr_d = clr_q + AW'(1);
      end
      ffa_pkg::ST_IDLE: begin
        if (accept) begin
          n_d = n_calc; bu_d = s_axis_tdata[35:20];
          ok_d = 1'b0; fail_d = 1'b0; gctx_d = 1'b0;
        end
      end
      ffa_pkg::ST_A_START: begin
        nx_raddr = cursor_q; prev_d = cursor_q;
      end
      ffa_pkg::ST_A_FIRST: begin
        p_d = nx_rdata; nx_raddr = nx_rdata; sz_raddr = nx_rdata;
      end
      ffa_pkg::ST_A_CHECK: begin
        alu_a = CW'(sz_rdata); alu_b = CW'(n_q); alu_sub = 1'b1;
        if (fit_ge) begin
          if (fit_eq) begin
            nx_we = 1'b1; nx_waddr = prev_q; nx_wdata = nx_rdata;
            lv_we = 1'b1; lv_waddr = p_q; lv_wdata = 1'b1;
            hdr_d = p_q; cursor_d = prev_q; ok_d = 1'b1;
          end else begin
            // Keep the head of the block free and hand out its tail end.
            sz_we = 1'b1; sz_waddr = p_q; sz_wdata = alu_res[AW-1:0];
            bsize_d = alu_res[AW-1:0];
          end
        end else if (p_q != cursor_q) begin
          prev_d = p_q; p_d = nx_rdata; nx_raddr = nx_rdata; sz_raddr = nx_rdata;
        end
      end
      ffa_pkg::ST_A_SPLIT: begin
        alu_a = CW'(p_q); alu_b = CW'(bsize_q);
        sz_we = 1'b1; sz_waddr = alu_res[AW-1:0]; sz_wdata = AW'(n_q);
        lv_we = 1'b1; lv_waddr = alu_res[AW-1:0]; lv_wdata = 1'b1;
        hdr_d = alu_res[AW-1:0]; cursor_d = prev_q; ok_d = 1'b1;
      end
      ffa_pkg::ST_G_ROOM: begin
        alu_a = LastUnit; alu_b = CW'(top_q); alu_sub = 1'b1;
        room_d = alu_res;
      end
      ffa_pkg::ST_G_CHK: begin
        if (room_q < CW'(n_q)) begin
          fail_d = 1'b1;
        end else begin
          sz_we = 1'b1; sz_waddr = top_q; sz_wdata = g_units[AW-1:0];
          bsize_d = g_units[AW-1:0]; bp_d = top_q;
        end
      end
      ffa_pkg::ST_G_TOP: begin
        alu_a = CW'(top_q); alu_b = CW'(bsize_q);
        top_d = alu_res[AW-1:0]; gctx_d = 1'b1;
      end
      ffa_pkg::ST_F_START: begin
        alu_a = CW'(bu_q); alu_b = CW'(1); alu_sub = 1'b1;
        bp_d = alu_res[AW-1:0];
        sz_raddr = alu_res[AW-1:0]; lv_raddr = alu_res[AW-1:0];
      end
      ffa_pkg::ST_F_CHK: begin
        if (lv_rdata) begin
          lv_we = 1'b1; lv_waddr = bp_q; lv_wdata = 1'b0;
          bsize_d = sz_rdata;
        end
      end
      ffa_pkg::ST_I_START: begin
        p_d = cursor_q; nx_raddr = cursor_q;
      end
      ffa_pkg::ST_I_WALK: begin
        if (walk_stop) begin
          up_d = nx_rdata; sz_raddr = nx_rdata; nx_raddr = nx_rdata;
        end else begin
          p_d = nx_rdata; nx_raddr = nx_rdata;
        end
      end
      ffa_pkg::ST_I_UP: begin
        alu_a = CW'(bp_q); alu_b = CW'(bsize_q);
        mu_d = (alu_res == CW'(up_q));
        upsz_d = sz_rdata; upnx_d = nx_rdata; sz_raddr = p_q;
      end
      ffa_pkg::ST_I_LOW: begin
        alu_a = CW'(bsize_q); alu_b = CW'(upsz_q);
        psz_d = sz_rdata;
        if (mu_q) begin
          bsize_d = alu_res[AW-1:0]; bnext_d = upnx_q;
        end else begin
          bnext_d = up_q;
        end
      end
      ffa_pkg::ST_I_WB: begin
        alu_a = CW'(p_q); alu_b = CW'(psz_q);
        ml_d = (alu_res == CW'(bp_q));
        nx_we = 1'b1; nx_waddr = bp_q; nx_wdata = bnext_q;
        sz_we = mu_q; sz_waddr = bp_q; sz_wdata = bsize_q;
      end
      ffa_pkg::ST_I_LOW2: begin
        alu_a = CW'(psz_q); alu_b = CW'(bsize_q);
        nx_we = 1'b1; nx_waddr = p_q;
        if (ml_q) begin
          sz_we = 1'b1; sz_waddr = p_q; sz_wdata = alu_res[AW-1:0];
          nx_wdata = bnext_q;
        end else begin
          nx_wdata = bp_q;
        end
        cursor_d = p_q;
      end
      ffa_pkg::ST_RESP: begin
        if (slot_free) begin
          mv_d = 1'b1;
          md_d = ok_q ? pay_sum[15:0] : 16'd0;
          mu_fail_d = fail_q;
        end
      end
      default: begin
        clr_d = clr_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ffa_pkg::ST_CLEAR;
      cursor_q <= '0; top_q <= AW'(1); clr_q <= '0;
      prev_q <= '0; p_q <= '0; bp_q <= '0; bsize_q <= '0; up_q <= '0;
      upsz_q <= '0; upnx_q <= '0; bnext_q <= '0; psz_q <= '0; hdr_q <= '0;
      room_q <= '0; n_q <= '0; bu_q <= '0; grow_q <= ffa_pkg::GROW_RESET;
      mu_q <= 1'b0; ml_q <= 1'b0; gctx_q <= 1'b0; ok_q <= 1'b0; fail_q <= 1'b0;
      mv_q <= 1'b0; md_q <= '0; mu_fail_q <= 1'b0;
    end else begin
      st_q <= st_d;
      cursor_q <= cursor_d; top_q <= top_d; clr_q <= clr_d;
      prev_q <= prev_d; p_q <= p_d; bp_q <= bp_d; bsize_q <= bsize_d; up_q <= up_d;
      upsz_q <= upsz_d; upnx_q <= upnx_d; bnext_q <= bnext_d; psz_q <= psz_d;
      hdr_q <= hdr_d; room_q <= room_d; n_q <= n_d; bu_q <= bu_d; grow_q <= grow_d;
      mu_q <= mu_d; ml_q <= ml_d; gctx_q <= gctx_d; ok_q <= ok_d; fail_q <= fail_d;
      mv_q <= mv_d; md_q <= md_d; mu_fail_q <= mu_fail_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_cursor_in_arena: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cursor_q < top_q) else $error("free cursor outside the arena");
  a_top_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    top_q <= LastAddr) else $error("arena top beyond its limit");
  a_top_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> top_q >= $past(top_q)) else $error("arena top shrank");
  a_fail_no_grant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == 16'd0)
    else $error("failed allocation carries a payload unit");
`endif

endmodule

// File: hdl/ffa_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
module ffa_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/ffa_alu.sv
// Shared adder and subtractor with a carry out, used by the sequencer steps that add or subtract.
module ffa_alu #(
  parameter int unsigned Width = 18
) (
  input  logic [Width-1:0] a_i,
  input  logic [Width-1:0] b_i,
  input  logic             sub_i,
  output logic [Width-1:0] res_o,
  output logic             carry_o
);

  logic [Width:0] sum;

  // A set carry on a subtraction means that a is not below b.
  assign sum     = {1'b0, a_i} + {1'b0, (sub_i ? ~b_i : b_i)} + {{Width{1'b0}}, sub_i};
  assign res_o   = sum[Width-1:0];
  assign carry_o = sum[Width];

endmodule
